### src/qdd_pkg.sv
// ----------------------------------------------------------------------------
// qdd_pkg: shared types and constants
// Op codes, register map, quadrature transition table and the structs
// that pass between the top level and the per-channel logic.
// ----------------------------------------------------------------------------
package qdd_pkg;

  localparam int CHANNELS   = 2;
  localparam int STEP_WIDTH = 16;
  localparam int TIME_W     = 32;
  localparam int DEB_W      = 16;
  localparam int DET_W      = 4;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(50);
  localparam logic [DET_W-1:0] DETENT_RST   = DET_W'(4);

  localparam logic signed [STEP_WIDTH-1:0] STEP_MAX = {1'b0, {(STEP_WIDTH-1){1'b1}}};
  localparam logic signed [STEP_WIDTH-1:0] STEP_MIN = {1'b1, {(STEP_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_BUTTON = 2'd1,
    OP_POLL   = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_DETENT   = 1'b1
  } reg_e;

  typedef struct packed {
    logic sel;           // this channel, transaction advancing
    op_e  op;
    logic level_a;
    logic level_b;
    logic button_level;
  } chan_req_t;

  typedef struct packed {
    logic notify;
    logic right_spin;
    logic left_spin;
    logic pressed;
  } res_t;

  // quadrature transition table, index = {prev_ab, cur_ab}
  function automatic logic signed [1:0] quad_move(input logic [3:0] idx);
    logic signed [1:0] mv;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: mv = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: mv = 2'sd1;
      default: mv = 2'sd0;
    endcase
    return mv;
  endfunction

endpackage

### src/qdd_if.sv
// ----------------------------------------------------------------------------
// qdd_if: stream channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface qdd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       channel;
  logic       level_a;
  logic       level_b;
  logic       button_level;

  modport source (output valid, op, channel, level_a, level_b, button_level,
                  input ready);
  modport sink (input valid, op, channel, level_a, level_b, button_level,
                output ready);
endinterface

interface qdd_out_if;
  logic valid;
  logic ready;
  logic notify;
  logic right_spin;
  logic left_spin;
  logic pressed;

  modport source (output valid, notify, right_spin, left_spin, pressed,
                  input ready);
  modport sink (input valid, notify, right_spin, left_spin, pressed,
                output ready);
endinterface

### src/qdd_chan.sv
// ----------------------------------------------------------------------------
// qdd_chan: one encoder channel
// Holds the channel's line levels, step count, press flag and press time;
// computes the result for a transaction addressed to it.
// ----------------------------------------------------------------------------
module qdd_chan (
  input  logic                               clk,
  input  logic                               rst_n,
  input  qdd_pkg::chan_req_t                 req,
  input  logic [qdd_pkg::TIME_W-1:0]         now_ms,
  input  logic [qdd_pkg::DEB_W-1:0]          debounce_ms,
  input  logic [qdd_pkg::DET_W-1:0]          detent_steps,
  output qdd_pkg::res_t                      res
);
  import qdd_pkg::*;

  logic [1:0]                   last_ab_r, last_ab_nxt;
  logic signed [STEP_WIDTH-1:0] step_r, step_nxt;
  logic                         pend_r, pend_nxt;
  logic [TIME_W-1:0]            press_t_r, press_t_nxt;

  logic [1:0]                   cur_ab;
  logic signed [1:0]            mv;
  logic signed [STEP_WIDTH:0]   step_x;
  logic signed [STEP_WIDTH:0]   sum;
  logic signed [STEP_WIDTH-1:0] sat;
  logic [TIME_W-1:0]            elapsed;
  logic [DET_W-1:0]             det;
  logic signed [STEP_WIDTH:0]   det_x;
  logic                         btn_ok;

  assign cur_ab  = {req.level_a, req.level_b};
  assign mv      = quad_move({last_ab_r, cur_ab});
  assign step_x  = {step_r[STEP_WIDTH-1], step_r};
  assign sum     = step_x + {{(STEP_WIDTH-1){mv[1]}}, mv};
  // overflow when the two top bits differ
  assign sat     = (sum[STEP_WIDTH] != sum[STEP_WIDTH-1]) ?
                   (sum[STEP_WIDTH] ? STEP_MIN : STEP_MAX) : sum[STEP_WIDTH-1:0];
  assign elapsed = now_ms - press_t_r;
  assign btn_ok  = !req.button_level && (elapsed >= TIME_W'(debounce_ms));
  assign det     = (detent_steps == '0) ? DET_W'(1) : detent_steps;
  assign det_x   = (STEP_WIDTH+1)'(det);

  always_comb begin
    last_ab_nxt = last_ab_r;
    step_nxt    = step_r;
    pend_nxt    = pend_r;
    press_t_nxt = press_t_r;
    res         = '0;
    if (req.sel) begin
      case (req.op)
        OP_SAMPLE: begin
          last_ab_nxt = cur_ab;
          step_nxt    = sat;
          res.notify  = (mv != 2'sd0);
        end
        OP_BUTTON: begin
          if (btn_ok) begin
            pend_nxt    = 1'b1;
            press_t_nxt = now_ms;
            res.notify  = 1'b1;
          end
        end
        OP_POLL: begin
          if (step_x >= det_x) begin
            step_nxt       = STEP_WIDTH'(step_x - det_x);
            res.right_spin = 1'b1;
          end else if (step_x <= -det_x) begin
            step_nxt      = STEP_WIDTH'(step_x + det_x);
            res.left_spin = 1'b1;
          end
          res.pressed = pend_r;
          pend_nxt    = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ab_r <= 2'b11;
      step_r    <= '0;
      pend_r    <= 1'b0;
      press_t_r <= '0;
    end else begin
      last_ab_r <= last_ab_nxt;
      step_r    <= step_nxt;
      pend_r    <= pend_nxt;
      press_t_r <= press_t_nxt;
    end
  end

endmodule

### src/quadrature_detent_decoder_top.sv
// ----------------------------------------------------------------------------
// quadrature_detent_decoder_top: rotary encoder front end
// Two encoder channels with quadrature step counting, detent reporting and
// button debounce against a millisecond tick clock.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction per event - pin sample, button falling edge,
//            poll, or millisecond tick (op field), with channel and levels.
//   out_ch : exactly one result transaction per input transaction, in order.
//   cfg_*  : APB write/read of debounce_ms (0x0) and detent_steps (0x4);
//            write only while no transaction is in flight.
// Pipeline: input register, then the channel update feeding the result
//   register; while out_ch.ready is low an item can wait in either.
// Throughput: 1 transaction per cycle while out_ch.ready stays high; the
//   channel update is a single table lookup plus a saturating add/compare
//   per cycle.
// Reset (rst_n low, synchronous): lines idle high, counts, flags, press
//   times and the ms clock zero, registers to 50 ms and 4 steps.
// Stall: when out_ch.ready is low the result register holds, the input
//   register still fills once, then in_ch.ready drops until the result
//   is taken.
// ----------------------------------------------------------------------------
module quadrature_detent_decoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  qdd_in_if.sink                        in_ch,
  qdd_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [qdd_pkg::APB_AW-1:0]    cfg_paddr,
  input  logic [qdd_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [qdd_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import qdd_pkg::*;

  // --- configuration registers ---
  logic [DEB_W-1:0] debounce_r, debounce_nxt;
  logic [DET_W-1:0] detent_r, detent_nxt;
  logic             cfg_wr;
  reg_e             cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_e'(cfg_paddr[2]);

  always_comb begin
    debounce_nxt = debounce_r;
    detent_nxt   = detent_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_DEBOUNCE: debounce_nxt = cfg_pwdata[DEB_W-1:0];
        REG_DETENT:   detent_nxt   = cfg_pwdata[DET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEBOUNCE: cfg_prdata = APB_DW'(debounce_r);
      REG_DETENT:   cfg_prdata = APB_DW'(detent_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // --- stage 1: input register ---
  logic s1_valid_r, s1_valid_nxt;
  op_e  s1_op_r;
  logic s1_ch_r, s1_a_r, s1_b_r, s1_btn_r;
  logic s1_adv;
  logic in_fire;

  // --- stage 2: result register ---
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;
  res_t res_any;

  logic [TIME_W-1:0] now_ms_r, now_ms_nxt;

  // stage 1 moves on when the result register is empty or being drained
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  assign now_ms_nxt    = (s1_adv && s1_op_r == OP_TICK) ? now_ms_r + 1'b1 : now_ms_r;

  // --- per-channel state and update ---
  res_t ch_res [CHANNELS];

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    chan_req_t req;
    assign req.sel          = s1_adv && (int'(s1_ch_r) == i);
    assign req.op           = s1_op_r;
    assign req.level_a      = s1_a_r;
    assign req.level_b      = s1_b_r;
    assign req.button_level = s1_btn_r;

    qdd_chan u_chan (
      .clk          (clk),
      .rst_n        (rst_n),
      .req          (req),
      .now_ms       (now_ms_r),
      .debounce_ms  (debounce_r),
      .detent_steps (detent_r),
      .res          (ch_res[i])
    );
  end

  // only the addressed channel drives a nonzero result
  always_comb begin
    res_any = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      res_any = res_any | ch_res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RST;
      detent_r    <= DETENT_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      now_ms_r    <= '0;
    end else begin
      debounce_r  <= debounce_nxt;
      detent_r    <= detent_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      now_ms_r    <= now_ms_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= op_e'(in_ch.op);
      s1_ch_r  <= in_ch.channel;
      s1_a_r   <= in_ch.level_a;
      s1_b_r   <= in_ch.level_b;
      s1_btn_r <= in_ch.button_level;
    end
    if (s1_adv) begin
      out_res_r <= res_any;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.notify     = out_res_r.notify;
  assign out_ch.right_spin = out_res_r.right_spin;
  assign out_ch.left_spin  = out_res_r.left_spin;
  assign out_ch.pressed    = out_res_r.pressed;

  // --- assertions ---
  a_spin_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.right_spin && out_res_r.left_spin))
    else $error("both spin directions reported");

  a_notify_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.notify |->
      !out_res_r.right_spin && !out_res_r.left_spin && !out_res_r.pressed)
    else $error("notify together with poll fields");

  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_op_r == OP_TICK |=> now_ms_r == $past(now_ms_r) + 1'b1)
    else $error("ms clock did not advance on tick");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a full pipeline");

endmodule

### bench/qdd_detent_checker.sv
// ----------------------------------------------------------------------------
// qdd_detent_checker: result checker for the quadrature detent decoder
// Watches the input, result and APB channels. Keeps its own copy of the
// encoder state and registers, predicts one report per accepted input
// transaction and compares each accepted result against the oldest one.
// ----------------------------------------------------------------------------
module qdd_detent_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 in_op,
  input  logic                       in_channel,
  input  logic                       in_level_a,
  input  logic                       in_level_b,
  input  logic                       in_button_level,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_notify,
  input  logic                       out_right_spin,
  input  logic                       out_left_spin,
  input  logic                       out_pressed,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic                       cfg_pready,
  input  logic [qdd_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [qdd_pkg::APB_DW-1:0] cfg_pwdata,
  input  logic [qdd_pkg::APB_DW-1:0] cfg_prdata,
  output int                         err_count,
  output int                         outstanding
);
  import qdd_pkg::*;

  // step per {previous AB, current AB}
  localparam int QUAD_STEP [16] = '{ 0, -1,  1,  0,
                                     1,  0,  0, -1,
                                    -1,  0,  0,  1,
                                     0,  1, -1,  0};

  logic [1:0]                   prev_ab     [CHANNELS];
  logic signed [STEP_WIDTH-1:0] step_tally  [CHANNELS];
  logic                         press_flag  [CHANNELS];
  logic [TIME_W-1:0]            press_stamp [CHANNELS];
  logic [TIME_W-1:0]            ms_clock;
  logic [DEB_W-1:0]             debounce_cfg;
  logic [DET_W-1:0]             detent_cfg;
  res_t                         report_q [$];

  task automatic log_fail(input string msg);
    if (err_count < 10) $display("[%0t] checker: %s", $realtime, msg);
    err_count++;
  endtask

  // advance the encoder state by one item, return the report it causes
  task automatic decode_item(input op_e op, input logic ch, input logic a,
                             input logic b, input logic btn, output res_t rep);
    int                s;
    int                d;
    int                idx;
    logic [TIME_W-1:0] elapsed;
    rep = '0;
    if (op == OP_TICK) begin
      ms_clock = ms_clock + 1'b1;
    end else if (int'(ch) < CHANNELS) begin
      case (op)
        OP_SAMPLE: begin
          idx = int'({prev_ab[ch], a, b});
          s = int'(step_tally[ch]) + QUAD_STEP[idx];
          if (s > int'(STEP_MAX)) s = int'(STEP_MAX);
          if (s < int'(STEP_MIN)) s = int'(STEP_MIN);
          step_tally[ch] = STEP_WIDTH'(s);
          prev_ab[ch] = {a, b};
          rep.notify = (QUAD_STEP[idx] != 0);
        end
        OP_BUTTON: begin
          elapsed = ms_clock - press_stamp[ch];
          if (!btn && elapsed >= TIME_W'(debounce_cfg)) begin
            press_flag[ch]  = 1'b1;
            press_stamp[ch] = ms_clock;
            rep.notify      = 1'b1;
          end
        end
        default: begin
          d = (detent_cfg == '0) ? 1 : int'(detent_cfg);
          s = int'(step_tally[ch]);
          if (s >= d) begin
            step_tally[ch] = STEP_WIDTH'(s - d);
            rep.right_spin = 1'b1;
          end else if (s <= -d) begin
            step_tally[ch] = STEP_WIDTH'(s + d);
            rep.left_spin = 1'b1;
          end
          rep.pressed    = press_flag[ch];
          press_flag[ch] = 1'b0;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin : watch
    res_t                got;
    res_t                want;
    logic [APB_DW-1:0]   reg_val;
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prev_ab[i]     = 2'b11;
        step_tally[i]  = '0;
        press_flag[i]  = 1'b0;
        press_stamp[i] = '0;
      end
      ms_clock     = '0;
      debounce_cfg = DEBOUNCE_RST;
      detent_cfg   = DETENT_RST;
      err_count    = 0;
      report_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_notify, out_right_spin, out_left_spin, out_pressed};
        if (report_q.size() == 0) begin
          log_fail($sformatf("result n/r/l/p=%b with no transaction pending", got));
        end else begin
          want = report_q.pop_front();
          if (got !== want)
            log_fail($sformatf("n/r/l/p expected %b got %b", want, got));
        end
      end
      if (in_valid && in_ready) begin
        decode_item(op_e'(in_op), in_channel, in_level_a, in_level_b,
                    in_button_level, want);
        report_q.push_back(want);
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (reg_e'(cfg_paddr[2]) == REG_DEBOUNCE) debounce_cfg = cfg_pwdata[DEB_W-1:0];
          else                                      detent_cfg   = cfg_pwdata[DET_W-1:0];
        end else begin
          reg_val = (reg_e'(cfg_paddr[2]) == REG_DEBOUNCE) ? APB_DW'(debounce_cfg)
                                                           : APB_DW'(detent_cfg);
          if (cfg_prdata !== reg_val)
            log_fail($sformatf("read addr %0h expected %0h got %0h",
                               cfg_paddr, reg_val, cfg_prdata));
        end
      end
    end
    outstanding = report_q.size();
  end

endmodule

### bench/tb_quadrature_detent_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_quadrature_detent_decoder_top: testbench for the rotary encoder front end
// Directed sequences (full rotations, illegal jumps, debounce, detent of
// zero, register readback), a one-way spin on both channels with detents
// taken off both ends, then random phases of mostly legal rotation mixed
// with noise, presses, polls and ticks under several register settings and
// traffic patterns.
// ----------------------------------------------------------------------------
module tb_quadrature_detent_decoder_top;
  import qdd_pkg::*;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  qdd_in_if  in_ch ();
  qdd_out_if out_ch ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int err_count;
  int outstanding;

  quadrature_detent_decoder_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  qdd_detent_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_op           (in_ch.op),
    .in_channel      (in_ch.channel),
    .in_level_a      (in_ch.level_a),
    .in_level_b      (in_ch.level_b),
    .in_button_level (in_ch.button_level),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_notify      (out_ch.notify),
    .out_right_spin  (out_ch.right_spin),
    .out_left_spin   (out_ch.left_spin),
    .out_pressed     (out_ch.pressed),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .err_count       (err_count),
    .outstanding     (outstanding)
  );

  // --------------------------------------------------------------------------
  // Result side. ready changes on the falling edge. A hold-off request from
  // the stimulus loads a cycle count here; otherwise the current mode
  // decides: always ready, random stalls, or a rotating stall pattern.
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode   = RX_ALWAYS;
  int          hold_reqs = 0;      // bumped by stimulus right after a posedge
  int          hold_seen = 0;
  int          hold_len  = 48;
  int          hold_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_pos   = 0;

  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_left = hold_len;
      hold_seen = hold_reqs;
    end
    if (rst_n !== 1'b1) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ch.ready <= 1'b1;
        RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ch.ready <= stall_pat[0];
          stall_pat = {stall_pat[0], stall_pat[15:1]};
          pat_pos++;
          // new pattern after each full rotation of the register, never all stalls
          if (pat_pos == 16) begin
            pat_pos   = 0;
            stall_pat = 16'($urandom()) | 16'h0101;
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Transactions go out in bursts of random length with random
  // gaps; gaps_on = 0 gives back-to-back traffic.
  // --------------------------------------------------------------------------
  logic       gaps_on    = 1'b1;
  int         burst_left = 0;
  logic [1:0] line_ab [2] = '{2'b11, 2'b11};  // last levels sent per channel
  logic       spin_cw [2] = '{1'b1, 1'b0};    // current random spin direction

  // Drive one transaction at the falling edge, hold it until accepted.
  // valid stays high into the next transaction unless a gap starts there.
  task automatic send_item(input op_e op, input logic ch, input logic a,
                           input logic b, input logic btn);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.channel      <= ch;
    in_ch.level_a      <= a;
    in_ch.level_b      <= b;
    in_ch.button_level <= btn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_sample(input logic ch, input logic [1:0] ab);
    line_ab[ch] = ab;
    send_item(OP_SAMPLE, ch, ab[1], ab[0], 1'($urandom()));
  endtask

  // one legal quadrature step from the channel's last levels
  task automatic turn(input logic ch, input logic cw);
    logic [1:0] nxt;
    case (line_ab[ch])
      2'b11:   nxt = cw ? 2'b01 : 2'b10;
      2'b01:   nxt = cw ? 2'b00 : 2'b11;
      2'b00:   nxt = cw ? 2'b10 : 2'b01;
      default: nxt = cw ? 2'b11 : 2'b00;
    endcase
    send_sample(ch, nxt);
  endtask

  // non-sample ops carry random levels; the block must ignore them
  task automatic send_op(input op_e op, input logic ch, input logic btn);
    send_item(op, ch, 1'($urandom()), 1'($urandom()), btn);
  endtask

  // Stop offering, wait until every result is back, then let the pipe settle
  task automatic wait_quiet();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic apb_xfer(input logic wr, input reg_e idx, input logic [APB_DW-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // new register setting and traffic shape; only called when idle
  task automatic set_phase(input logic [DEB_W-1:0] deb, input logic [DET_W-1:0] det,
                           input rx_mode_e mode, input logic gaps);
    wait_quiet();
    apb_xfer(1'b1, REG_DEBOUNCE, APB_DW'(deb));
    apb_xfer(1'b1, REG_DETENT, APB_DW'(det));
    apb_xfer(1'b0, REG_DEBOUNCE, '0);
    apb_xfer(1'b0, REG_DETENT, '0);
    @(posedge clk);
    rx_mode = mode;
    gaps_on = gaps;
  endtask

  // mostly legal rotation runs with occasional reversals, plus noise
  task automatic random_item();
    int   r;
    logic ch;
    r  = $urandom_range(0, 99);
    ch = 1'($urandom());
    if (r < 45) begin
      if ($urandom_range(0, 7) == 0) spin_cw[ch] = !spin_cw[ch];
      turn(ch, spin_cw[ch]);
    end else if (r < 52) begin
      send_sample(ch, 2'($urandom()));
    end else if (r < 64) begin
      send_op(OP_BUTTON, ch, ($urandom_range(0, 4) == 0));
    end else if (r < 80) begin
      send_op(OP_POLL, ch, 1'($urandom()));
    end else begin
      send_op(OP_TICK, ch, 1'($urandom()));
    end
  endtask

  // hold_at: receiver holds off after that item; pause_at: sender drains
  task automatic random_phase(input int n, input int hold_at, input int pause_at);
    for (int i = 0; i < n; i++) begin
      random_item();
      if (i == hold_at) hold_reqs++;
      if (i == pause_at) wait_quiet();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_SAMPLE;
    in_ch.channel      = 1'b0;
    in_ch.level_a      = 1'b0;
    in_ch.level_b      = 1'b0;
    in_ch.button_level = 1'b1;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values of both registers
    apb_xfer(1'b0, REG_DEBOUNCE, '0);
    apb_xfer(1'b0, REG_DETENT, '0);
    @(posedge clk);
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;

    // ---- directed, reset settings (50 ms, 4 steps) ----
    send_sample(1'b0, 2'b11);             // same levels as idle: no move
    repeat (4) turn(1'b0, 1'b1);          // one full clockwise cycle
    send_op(OP_POLL, 1'b0, 1'b1);         // right spin
    repeat (4) turn(1'b1, 1'b0);          // one full counter-clockwise cycle
    send_op(OP_POLL, 1'b1, 1'b0);         // left spin
    send_sample(1'b0, 2'b00);             // illegal double-line jump
    send_sample(1'b0, 2'b11);             // and back: still no move
    send_op(OP_BUTTON, 1'b0, 1'b0);       // press at t=0: inside window
    send_op(OP_BUTTON, 1'b0, 1'b1);       // line high: no press
    send_op(OP_TICK, 1'b1, 1'b0);
    send_op(OP_POLL, 1'b0, 1'b0);         // nothing pending

    // ---- directed, zero debounce: every low edge counts ----
    set_phase(16'd0, DETENT_RST, RX_ALWAYS, 1'b1);
    send_op(OP_BUTTON, 1'b1, 1'b0);
    send_op(OP_BUTTON, 1'b1, 1'b0);       // zero elapsed still accepted
    send_op(OP_POLL, 1'b1, 1'b1);         // pressed
    send_op(OP_POLL, 1'b1, 1'b1);         // flag cleared by the first poll

    // ---- directed, detent of zero behaves as one ----
    set_phase(16'd0, 4'd0, RX_PATTERN, 1'b1);
    turn(1'b0, 1'b1);
    send_op(OP_POLL, 1'b0, 1'b0);
    turn(1'b0, 1'b0);
    send_op(OP_POLL, 1'b0, 1'b0);

    // ---- one-way spin on both channels, then detents off both ends ----
    set_phase(16'hFFFF, 4'd8, RX_ALWAYS, 1'b0);
    for (int i = 0; i < 10; i++) begin
      turn(1'b0, 1'b1);
      turn(1'b1, 1'b0);
    end
    turn(1'b0, 1'b1);
    turn(1'b1, 1'b0);
    send_op(OP_POLL, 1'b0, 1'b0);
    send_op(OP_POLL, 1'b1, 1'b0);
    turn(1'b0, 1'b0);
    turn(1'b1, 1'b1);
    send_op(OP_POLL, 1'b0, 1'b0);
    send_op(OP_POLL, 1'b1, 1'b0);

    // ---- random phases ----
    // long receiver hold-off with the sender still pushing, and a
    // mid-phase pause until every result is back
    set_phase(16'd0, 4'd1, RX_RANDOM, 1'b1);
    random_phase(150, 40, 100);

    set_phase(16'($urandom_range(1, 12)), 4'd0, RX_PATTERN, 1'b1);
    random_phase(150, -1, 80);

    // back-to-back stretch with no idling on either side
    set_phase(16'hFFFF, 4'd15, RX_ALWAYS, 1'b0);
    random_phase(150, -1, -1);

    set_phase(16'($urandom_range(0, 6)), 4'($urandom_range(1, 15)), RX_RANDOM, 1'b1);
    hold_len = 64;
    random_phase(150, 20, 120);

    // ---- drain and verdict ----
    wait_quiet();
    repeat (6) @(posedge clk);
    if (err_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #1500000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
